// ===== rtl/core/mpec_pkg.sv =====
`default_nettype none

package mpec_pkg;

    // Field and fixed-point widths.
    localparam int COORD_W   = 10;
    localparam int ITER_W    = 13;
    localparam int FIX_W     = 32;
    localparam int FRAC_W    = 28;
    localparam int STEP_W    = 31;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int WIDE_W    = 44;
    localparam int MAX_ITER  = 4096;

    // Escape bound |z|^2 > 4.0 in Q4.28.
    localparam longint ESCAPE_BOUND = longint'(4) << FRAC_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic signed [FIX_W-1:0] ORIGIN_X_RST = -32'sd64290293;
    localparam logic signed [FIX_W-1:0] ORIGIN_Y_RST = 32'sd177167401;
    localparam logic [STEP_W-1:0]       STEP_X_RST   = 31'd3146;
    localparam logic [STEP_W-1:0]       STEP_Y_RST   = 31'd3146;
    localparam logic [ITER_W-1:0]       LIMIT_RST    = 13'd4096;

    // Colour ramp: quotients come from a reciprocal multiply plus one correction.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
    localparam int NUM_W       = 17;
    localparam int DIV_W       = 11;
    localparam int RECIP_W     = 25;
    localparam int QUO_W       = 7;

    localparam logic [RECIP_W-1:0] RECIP_1    = RECIP_W'(RECIP_ONE);
    localparam logic [RECIP_W-1:0] RECIP_126  = RECIP_W'(RECIP_ONE / 126);
    localparam logic [RECIP_W-1:0] RECIP_127  = RECIP_W'(RECIP_ONE / 127);
    localparam logic [RECIP_W-1:0] RECIP_255  = RECIP_W'(RECIP_ONE / 255);
    localparam logic [RECIP_W-1:0] RECIP_511  = RECIP_W'(RECIP_ONE / 511);
    localparam logic [RECIP_W-1:0] RECIP_1023 = RECIP_W'(RECIP_ONE / 1023);
    localparam logic [RECIP_W-1:0] RECIP_2047 = RECIP_W'(RECIP_ONE / 2047);

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] CHAN_FULL    = 8'd255;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_COL1,
        ST_COL2
    } state_t;

    // Request from the sequencer to the colour unit.
    typedef struct packed {
        logic              load;
        logic [ITER_W-1:0] count;
        logic [ITER_W-1:0] limit;
    } col_req_t;

    // One linear piece of the ramp: value = base + num / div.
    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [DIV_W-1:0]   div;
        logic [RECIP_W-1:0] recip;
        logic [7:0]         base;
        logic               green;
    } ramp_seg_t;

    // Picks the ramp piece for an iteration count.
    function automatic ramp_seg_t ramp_seg(input logic [ITER_W-1:0] count);
        ramp_seg_t s;
        s = '0;
        if (count < 13'd64)
        begin
            s.num   = NUM_W'({count, 1'b0});
            s.div   = 11'd1;
            s.recip = RECIP_1;
            s.base  = 8'd0;
        end
        else if (count < 13'd128)
        begin
            s.num   = NUM_W'(count - 13'd64) * 17'd128;
            s.div   = 11'd126;
            s.recip = RECIP_126;
            s.base  = 8'd128;
        end
        else if (count < 13'd256)
        begin
            s.num   = NUM_W'(count - 13'd128) * 17'd62;
            s.div   = 11'd127;
            s.recip = RECIP_127;
            s.base  = 8'd193;
        end
        else if (count < 13'd512)
        begin
            s.num   = NUM_W'(count - 13'd256) * 17'd62;
            s.div   = 11'd255;
            s.recip = RECIP_255;
            s.base  = 8'd1;
            s.green = 1'b1;
        end
        else if (count < 13'd1024)
        begin
            s.num   = NUM_W'(count - 13'd512) * 17'd63;
            s.div   = 11'd511;
            s.recip = RECIP_511;
            s.base  = 8'd64;
            s.green = 1'b1;
        end
        else if (count < 13'd2048)
        begin
            s.num   = NUM_W'(count - 13'd1024) * 17'd63;
            s.div   = 11'd1023;
            s.recip = RECIP_1023;
            s.base  = 8'd128;
            s.green = 1'b1;
        end
        else
        begin
            s.num   = NUM_W'(count - 13'd2048) * 17'd63;
            s.div   = 11'd2047;
            s.recip = RECIP_2047;
            s.base  = 8'd192;
            s.green = 1'b1;
        end
        return s;
    endfunction

    // Saturates a wide signed value to the signed 32-bit range.
    function automatic logic signed [FIX_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [FIX_W-1:0] r;
        if ((&v[WIDE_W-1:FIX_W-1]) || !(|v[WIDE_W-1:FIX_W-1]))
        begin
            r = v[FIX_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            r = {1'b1, {(FIX_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(FIX_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mpec_if.sv =====
`default_nettype none

// Pixel request channel: one beat names one pixel.
interface mpec_pix_if;
    logic       valid;
    logic       ready;
    logic [9:0] row;
    logic [9:0] col;

    modport source (output valid, output row, output col, input ready);
    modport sink   (input valid, input row, input col, output ready);
endinterface

// Result channel: one beat per pixel.
interface mpec_res_if;
    logic        valid;
    logic        ready;
    logic [12:0] iterations;
    logic [31:0] rgba;

    modport source (output valid, output iterations, output rgba, input ready);
    modport sink   (input valid, input iterations, input rgba, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mpec_color.sv =====
`default_nettype none

// Two-stage colour ramp. Stage one picks the ramp piece and forms an
// estimate of the quotient by a reciprocal multiply; stage two corrects
// the estimate by one and packs the colour word.
module mpec_color (
    input  wire logic              clk,
    input  wire mpec_pkg::col_req_t req,
    output logic [31:0]            rgba
);
    import mpec_pkg::*;

    ramp_seg_t                 seg;
    logic [NUM_W+RECIP_W-1:0]  est_prod;

    logic [NUM_W-1:0]          num_reg;
    logic [DIV_W-1:0]          div_reg;
    logic [7:0]                base_reg;
    logic                      green_reg;
    logic                      black_reg;
    logic [QUO_W-1:0]          quo_reg;

    logic [NUM_W:0]            quo_div;
    logic [NUM_W:0]            rem;
    logic                      fix;
    logic [7:0]                chan;
    logic [7:0]                red;
    logic [7:0]                green;

    // Stage one: segment select and quotient estimate.
    always_comb
    begin
        seg      = ramp_seg(req.count);
        est_prod = (NUM_W+RECIP_W)'(seg.num) * (NUM_W+RECIP_W)'(seg.recip);
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            num_reg   <= seg.num;
            div_reg   <= seg.div;
            base_reg  <= seg.base;
            green_reg <= seg.green;
            black_reg <= !(req.count < req.limit);
            quo_reg   <= est_prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
        end
    end

    // Stage two: the estimate is at most one low.
    always_comb
    begin
        quo_div = (NUM_W+1)'(quo_reg) * (NUM_W+1)'(div_reg);
        rem     = (NUM_W+1)'(num_reg) - quo_div;
        fix     = (rem >= (NUM_W+1)'(div_reg));
        chan    = base_reg + 8'(quo_reg) + 8'(fix);
        red     = green_reg ? CHAN_FULL : chan;
        green   = green_reg ? chan : 8'd0;
        if (black_reg)
        begin
            rgba = {24'd0, ALPHA_OPAQUE};
        end
        else
        begin
            rgba = {red, green, 8'd0, ALPHA_OPAQUE};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mandelbrot_pixel_escape_color.sv =====
// Sequence: for an accepted pixel beat, each iteration runs through the multiply state and
// then the update state of the shared unit until the pixel escapes or reaches the limit,
// and the color ramp then runs through the states COL1 and COL2.
// One pixel is in flight at a time; a new pixel is taken only in the idle state, after the
// previous result is loaded; that result waits in the output register while the next is taken.
// Reset: rst_n is asynchronous and active low; configuration returns to its defaults.
`default_nettype none

module mandelbrot_pixel_escape_color (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [mpec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mpec_pkg::CFG_W-1:0]      cfg_data,
    mpec_pix_if.sink                             pixel,
    mpec_res_if.source                           result
);
    import mpec_pkg::*;

    state_t                     state_reg;
    state_t                     state_next;

    logic signed [FIX_W-1:0]    origin_x_reg;
    logic signed [FIX_W-1:0]    origin_y_reg;
    logic [STEP_W-1:0]          step_x_reg;
    logic [STEP_W-1:0]          step_y_reg;
    logic [ITER_W-1:0]          limit_reg;

    logic signed [FIX_W-1:0]    xc_reg;
    logic signed [FIX_W-1:0]    yc_reg;
    logic signed [FIX_W-1:0]    x_reg;
    logic signed [FIX_W-1:0]    y_reg;
    logic signed [2*FIX_W-1:0]  pxx_reg;
    logic signed [2*FIX_W-1:0]  pyy_reg;
    logic signed [2*FIX_W-1:0]  pxy_reg;
    logic [ITER_W-1:0]          it_reg;

    logic                       res_valid_reg;
    logic [ITER_W-1:0]          res_iter_reg;
    logic [31:0]                res_rgba_reg;

    logic [ITER_W-1:0]          lim;
    logic                       accept;
    logic                       mul_en;
    logic                       upd_en;
    logic                       out_load;
    logic                       escape;
    logic [ITER_W-1:0]          it_inc;

    logic [STEP_W+COORD_W-1:0]  col_prod;
    logic [STEP_W+COORD_W-1:0]  row_prod;
    logic signed [FIX_W-1:0]    xc_new;
    logic signed [FIX_W-1:0]    yc_new;

    logic signed [2*FIX_W-FRAC_W-1:0] x2;
    logic signed [2*FIX_W-FRAC_W-1:0] y2;
    logic signed [2*FIX_W-FRAC_W:0]   mag;
    logic signed [2*FIX_W-FRAC_W:0]   two_xy;
    logic signed [FIX_W-1:0]          x_new;
    logic signed [FIX_W-1:0]          y_new;

    col_req_t                   col_req;
    logic [31:0]                col_rgba;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= ORIGIN_X_RST;
            origin_y_reg <= ORIGIN_Y_RST;
            step_x_reg   <= STEP_X_RST;
            step_y_reg   <= STEP_Y_RST;
            limit_reg    <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data[FIX_W-1:0];
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data[FIX_W-1:0];
                CFG_STEP_X:   step_x_reg   <= cfg_data[STEP_W-1:0];
                CFG_STEP_Y:   step_y_reg   <= cfg_data[STEP_W-1:0];
                CFG_LIMIT:    limit_reg    <= cfg_data[ITER_W-1:0];
                default:      ;
            endcase
        end
    end

    // Effective limit, capped at the maximum iteration count.
    assign lim = (limit_reg > ITER_W'(MAX_ITER)) ? ITER_W'(MAX_ITER) : limit_reg;

    // Point c for the incoming pixel.
    always_comb
    begin
        col_prod = (STEP_W+COORD_W)'(step_x_reg) * (STEP_W+COORD_W)'(pixel.col);
        row_prod = (STEP_W+COORD_W)'(step_y_reg) * (STEP_W+COORD_W)'(pixel.row);
        xc_new   = sat32(WIDE_W'(origin_x_reg) + $signed(WIDE_W'(col_prod)));
        yc_new   = sat32(WIDE_W'(origin_y_reg) - $signed(WIDE_W'(row_prod)));
    end

    // Escape test and z update from the registered products.
    always_comb
    begin
        x2     = pxx_reg[2*FIX_W-1:FRAC_W];
        y2     = pyy_reg[2*FIX_W-1:FRAC_W];
        two_xy = pxy_reg[2*FIX_W-1:FRAC_W-1];
        mag    = (2*FIX_W-FRAC_W+1)'(x2) + (2*FIX_W-FRAC_W+1)'(y2);
        escape = (mag > (2*FIX_W-FRAC_W+1)'(ESCAPE_BOUND));
        x_new  = sat32(WIDE_W'(x2) - WIDE_W'(y2) + WIDE_W'(xc_reg));
        y_new  = sat32(WIDE_W'(two_xy) + WIDE_W'(yc_reg));
        it_inc = it_reg + 13'd1;
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel.valid)
                begin
                    state_next = (lim == '0) ? ST_COL1 : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (escape || (it_inc == lim))
                begin
                    state_next = ST_COL1;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_COL1:
            begin
                state_next = ST_COL2;
            end
            ST_COL2:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        pixel.ready = 1'b0;
        mul_en      = 1'b0;
        upd_en      = 1'b0;
        out_load    = 1'b0;
        col_req     = '{load: 1'b0, count: it_reg, limit: lim};
        case (state_reg)
            ST_IDLE: pixel.ready  = 1'b1;
            ST_MUL:  mul_en       = 1'b1;
            ST_UPD:  upd_en       = !escape;
            ST_COL1: col_req.load = 1'b1;
            ST_COL2: out_load     = !res_valid_reg || result.ready;
            default: ;
        endcase
    end

    assign accept = pixel.valid && pixel.ready;

    // Shared iteration unit: the multiply state registers the products, the update state uses them in the next cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xc_reg <= xc_new;
            yc_reg <= yc_new;
            x_reg  <= '0;
            y_reg  <= '0;
            it_reg <= '0;
        end
        else if (upd_en)
        begin
            x_reg  <= x_new;
            y_reg  <= y_new;
            it_reg <= it_inc;
        end
        if (mul_en)
        begin
            pxx_reg <= (2*FIX_W)'(x_reg) * (2*FIX_W)'(x_reg);
            pyy_reg <= (2*FIX_W)'(y_reg) * (2*FIX_W)'(y_reg);
            pxy_reg <= (2*FIX_W)'(x_reg) * (2*FIX_W)'(y_reg);
        end
    end

    mpec_color u_color (
        .clk  (clk),
        .req  (col_req),
        .rgba (col_rgba)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_iter_reg <= it_reg;
            res_rgba_reg <= col_rgba;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.iterations = res_iter_reg;
    assign result.rgba       = res_rgba_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mpec_checker.sv =====
`default_nettype none

module mpec_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pix_valid,
    input wire logic        pix_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [12:0] res_iterations,
    input wire logic [31:0] res_rgba
);

    // A result beat holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_rgba)
            && $stable(res_iterations))
        else $error("result beat dropped or changed while stalled");

    // One pixel at a time: the block is busy right after a pixel beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready |=> !pix_ready)
        else $error("pixel taken while the previous one is in flight");

    // The count never exceeds the maximum limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_iterations <= 13'd4096)
        else $error("iteration count out of range");

    // Blue is always zero and alpha always opaque.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_rgba[15:8] == 8'd0 && res_rgba[7:0] == 8'd255)
        else $error("blue or alpha byte wrong");

    // Green shows only once red has reached full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_rgba[31:24] != 8'd255 |-> res_rgba[23:16] == 8'd0)
        else $error("green set before red saturates");

endmodule

bind mandelbrot_pixel_escape_color mpec_checker u_mpec_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_valid      (pixel.valid),
    .pix_ready      (pixel.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_iterations (result.iterations),
    .res_rgba       (result.rgba)
);

`default_nettype wire

// ===== tb/mandelbrot_pixel_escape_color_tb.sv =====
`timescale 1ns / 100ps

module mandelbrot_pixel_escape_color_tb;
    import mpec_pkg::*;

    localparam int CYCLE_LIMIT      = 4_000_000;
    localparam int PIXELS_PER_PHASE = 16;
    localparam int RANDOM_PHASES    = 7;
    localparam int MAX_REPORTS      = 10;
    localparam int Q_ONE            = 1 << FRAC_W;
    localparam int Q_QUARTER        = Q_ONE / 4;
    // About 3.0 / 1024 in Q4.28, so 1024 pixels span the whole set.
    localparam int FULL_STEP        = 786432;

    // One predicted pixel result, with its coordinates for reporting.
    typedef struct {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [ITER_W-1:0]  iterations;
        logic [31:0]        rgba;
    } pixel_color_t;

    // Keeps a copy of the window registers, predicts each pixel and checks results.
    class escape_tracker;
        logic signed [FIX_W-1:0] origin_x;
        logic signed [FIX_W-1:0] origin_y;
        logic [STEP_W-1:0]       step_x;
        logic [STEP_W-1:0]       step_y;
        logic [ITER_W-1:0]       iteration_limit;
        pixel_color_t            expected_colors[$];
        int                      mismatches;
        int                      checked;
        int                      black_pixels;

        function new();
            origin_x        = ORIGIN_X_RST;
            origin_y        = ORIGIN_Y_RST;
            step_x          = STEP_X_RST;
            step_y          = STEP_Y_RST;
            iteration_limit = LIMIT_RST;
            mismatches      = 0;
            checked         = 0;
            black_pixels    = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
            case (index)
                CFG_ORIGIN_X: origin_x = data;
                CFG_ORIGIN_Y: origin_y = data;
                CFG_STEP_X:   step_x = data[STEP_W-1:0];
                CFG_STEP_Y:   step_y = data[STEP_W-1:0];
                CFG_LIMIT:    iteration_limit = data[ITER_W-1:0];
                default:      ;
            endcase
        endfunction

        function longint clamp32(input longint v);
            if (v > longint'(32'h7FFF_FFFF))
            begin
                return longint'(32'h7FFF_FFFF);
            end
            if (v < -longint'(32'h8000_0000))
            begin
                return -longint'(32'h8000_0000);
            end
            return v;
        endfunction

        // Piecewise-linear red/green ramp; pixels at the limit stay black.
        function logic [31:0] ramp_rgba(input int unsigned count, input int unsigned lim);
            int unsigned r;
            int unsigned g;
            r = 0;
            g = 0;
            if (count < lim)
            begin
                if (count < 64)
                begin
                    r = count * 2;
                end
                else if (count < 128)
                begin
                    r = ((count - 64) * 128) / 126 + 128;
                end
                else if (count < 256)
                begin
                    r = ((count - 128) * 62) / 127 + 193;
                end
                else if (count < 512)
                begin
                    r = 255;
                    g = ((count - 256) * 62) / 255 + 1;
                end
                else if (count < 1024)
                begin
                    r = 255;
                    g = ((count - 512) * 63) / 511 + 64;
                end
                else if (count < 2048)
                begin
                    r = 255;
                    g = ((count - 1024) * 63) / 1023 + 128;
                end
                else
                begin
                    r = 255;
                    g = ((count - 2048) * 63) / 2047 + 192;
                end
            end
            return {r[7:0], g[7:0], 8'h00, ALPHA_OPAQUE};
        endfunction

        // Escape-time iteration in Q4.28 with floored products and saturation.
        function pixel_color_t escape_color(input logic [COORD_W-1:0] row,
                                            input logic [COORD_W-1:0] col);
            pixel_color_t p;
            int unsigned  lim;
            int unsigned  count;
            longint       xc;
            longint       yc;
            longint       x;
            longint       y;
            longint       x2;
            longint       y2;
            longint       xy2;
            lim   = (iteration_limit > MAX_ITER) ? MAX_ITER : iteration_limit;
            xc    = clamp32(longint'(origin_x) + longint'(step_x) * longint'(col));
            yc    = clamp32(longint'(origin_y) - longint'(step_y) * longint'(row));
            x     = 0;
            y     = 0;
            count = 0;
            while (count < lim)
            begin
                x2 = (x * x) >>> FRAC_W;
                y2 = (y * y) >>> FRAC_W;
                if (x2 + y2 > ESCAPE_BOUND)
                begin
                    break;
                end
                xy2 = (x * y) >>> (FRAC_W - 1);
                x   = clamp32(x2 - y2 + xc);
                y   = clamp32(xy2 + yc);
                count++;
            end
            p.row        = row;
            p.col        = col;
            p.iterations = count[ITER_W-1:0];
            p.rgba       = ramp_rgba(count, lim);
            return p;
        endfunction

        function void note_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
            expected_colors.push_back(escape_color(row, col));
        endfunction

        function void check_result(input logic [ITER_W-1:0] iterations, input logic [31:0] rgba);
            pixel_color_t want;
            checked++;
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("ERROR: result beat with no pixel outstanding: iterations %0d rgba %h",
                             iterations, rgba);
                end
                return;
            end
            want = expected_colors.pop_front();
            if (want.rgba[31:8] == 24'h0)
            begin
                black_pixels++;
            end
            if (iterations !== want.iterations || rgba !== want.rgba)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("ERROR: pixel (%0d,%0d): count exp %0d got %0d, rgba exp %h got %h",
                             want.row, want.col, want.iterations, iterations, want.rgba, rgba);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    bit                   sender_idles;
    bit                   receiver_stalls;
    int                   settings_used;
    int                   random_pixels;
    escape_tracker        tracker;

    mpec_pix_if pixel_bus ();
    mpec_res_if result_bus ();

    mandelbrot_pixel_escape_color dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_bus),
        .result    (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Writes one register; the caller lowers the write enable after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        tracker.write_reg(index, data);
        @(posedge clk);
    endtask

    task automatic write_window(input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] sx, input logic [31:0] sy,
                                input logic [31:0] lim);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_STEP_X, sx);
        write_reg(CFG_STEP_Y, sy);
        write_reg(CFG_LIMIT, lim);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic write_limit(input logic [31:0] lim);
        write_reg(CFG_LIMIT, lim);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Sends one pixel beat; valid stays high into the next beat when there is no gap.
    task automatic send_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
        int gap;
        gap = sender_idles ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            pixel_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_bus.valid <= 1'b1;
        pixel_bus.row   <= row;
        pixel_bus.col   <= col;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
        tracker.note_pixel(row, col);
    endtask

    // Holds the sender until every outstanding result beat has been checked.
    task automatic drain_results();
        pixel_bus.valid <= 1'b0;
        while (tracker.expected_colors.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Result side: random stall before each beat, none while stalls are off.
    initial
    begin
        int gap;
        result_bus.ready <= 1'b0;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            gap = receiver_stalls ? $urandom_range(0, 11) : 0;
            if (gap > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_bus.valid);
        end
    end

    // Check every accepted result beat.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            tracker.check_result(result_bus.iterations, result_bus.rgba);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Run stopped after %0d cycles without finishing", CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int cusp_cols_coarse[5];
        int cusp_cols_fine[6];
        int phase;
        int i;
        int ox;
        int oy;
        int unsigned sx;
        int unsigned sy;
        int unsigned lim;

        cusp_cols_coarse = '{1023, 100, 30, 8, 2};
        cusp_cols_fine   = '{1023, 600, 300, 200, 100, 0};
        tracker          = new();
        settings_used    = 1;
        random_pixels    = 0;
        sender_idles     = 1'b1;
        receiver_stalls  = 1'b1;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_ORIGIN_X;
        cfg_data        <= '0;
        pixel_bus.valid <= 1'b0;
        pixel_bus.row   <= '0;
        pixel_bus.col   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners and alternating bit patterns in the window left by reset.
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        drain_results();

        // Points just right of the cusp at c = 0.25 escape late, reaching every ramp band.
        write_window(Q_QUARTER, 0, 4096, 0, MAX_ITER);
        foreach (cusp_cols_coarse[k])
        begin
            send_pixel(10'd1023, COORD_W'(cusp_cols_coarse[k]));
        end
        drain_results();
        write_window(Q_QUARTER, 0, 2, 0, MAX_ITER);
        foreach (cusp_cols_fine[k])
        begin
            send_pixel(10'd0, COORD_W'(cusp_cols_fine[k]));
        end
        drain_results();

        // Whole set: c = -2 sits on the escape bound, c = 0.25 never escapes.
        write_window(-2 * Q_ONE, 3 * Q_ONE / 2, FULL_STEP, FULL_STEP, 300);
        send_pixel(10'd512, 10'd0);
        send_pixel(10'd512, 10'd768);
        send_pixel(10'd0, 10'd0);
        drain_results();

        // Both coordinates saturate; the limit field above the maximum is clamped.
        write_window(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1FFF);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd0);
        drain_results();

        // A limit of zero does no iteration, a limit of one always ends black.
        write_limit(0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd512, 10'd0);
        drain_results();
        write_limit(1);
        send_pixel(10'd0, 10'd0);
        drain_results();

        // Random pixels over a series of windows; some phases run without idling.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            sender_idles    = (phase % 3) != 1;
            receiver_stalls = (phase % 3) != 2;
            case (phase)
                0:
                begin
                    write_window(ORIGIN_X_RST, ORIGIN_Y_RST, 32'(STEP_X_RST),
                                 32'(STEP_Y_RST), 32'(LIMIT_RST));
                end
                1, 4:
                begin
                    ox  = -2 * Q_ONE - int'($urandom_range(0, 1 << 24));
                    oy  = 3 * Q_ONE / 2 + int'($urandom_range(0, 1 << 24));
                    sx  = FULL_STEP - (1 << 16) + $urandom_range(0, 1 << 17);
                    sy  = FULL_STEP - (1 << 16) + $urandom_range(0, 1 << 17);
                    lim = $urandom_range(16, 600);
                    write_window(ox, oy, sx, sy, lim);
                end
                2, 5:
                begin
                    ox  = -2 * Q_ONE + int'($urandom_range(0, 671088640));
                    oy  = int'($urandom_range(0, 322122547));
                    sx  = $urandom_range(1, 16384);
                    sy  = $urandom_range(1, 16384);
                    lim = $urandom_range(1, 1024);
                    write_window(ox, oy, sx, sy, lim);
                end
                default:
                begin
                    write_window($urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom_range(0, 8191));
                end
            endcase
            for (i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                send_pixel(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)));
                random_pixels++;
            end
            drain_results();
        end

        // Let any stray result beat show up before the verdict.
        repeat (40) @(posedge clk);
        if (tracker.expected_colors.size() != 0)
        begin
            $display("ERROR: %0d expected results never arrived", tracker.expected_colors.size());
        end
        $display("Checked %0d pixel results over %0d register settings, %0d of them black.",
                 tracker.checked, settings_used, tracker.black_pixels);
        $display(
            "Covered saturated windows, limits 0, 1, >4096, every ramp band, %0d random pixels.",
            random_pixels);
        if (tracker.mismatches == 0 && tracker.expected_colors.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
